/* hw/rtl/conv3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// conv3_pkg: op codes, register indexes, fixed widths and sequencer states
// for the 3x3 convolution block. No dependencies.

package conv3_pkg;

    localparam int KSIZE     = 3;
    localparam int SUM_W     = 22;
    localparam int COORD_W   = 10;
    localparam int OP_W      = 2;
    localparam int ADDR_W    = 13;
    localparam int VAL_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 6;

    localparam logic [OP_W-1:0] OP_PIX  = 2'd0;
    localparam logic [OP_W-1:0] OP_WGT  = 2'd1;
    localparam logic [OP_W-1:0] OP_CONV = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd4;

    localparam logic [1:0] K_LAST = 2'(KSIZE - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_RUN   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/conv3_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// conv3_ram: generic simple dual-port RAM, one write and one registered read
// port. No dependencies.

module conv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/conv3x3_stride_padding_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// conv3x3_stride_padding_top: multichannel 3x3 integer convolution with stride
// and zero padding. Depends on conv3_pkg and conv3_ram.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat carries op, addr, value,
//   out_chan, out_row, out_col. op OP_PIX and OP_WGT write one signed byte into
//   the pixel or weight RAM and give no result. op OP_CONV returns one result
//   beat (conv_sum, bad_coord) on the output channel (out_valid / out_stall).
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Write registers only while the block is idle.
//   Compute: a compute beat walks the taps with the single multiply-accumulate,
//   one RAM read pair per cycle, through the states SETUP, PREP, RUN and DONE.
//   A coordinate outside the output goes from SETUP straight to DONE.
//   The output register holds a result under out_stall; a following load is
//   still taken, a following compute waits at its end until the register frees.
//   Reset: registers return to side 3, one channel in and out, stride 1, no
//   padding; both RAMs hold unknown data until written.

module conv3x3_stride_padding_top #(
    parameter int MAX_SIDE   = 32,
    parameter int MAX_IN_CH  = 8,
    parameter int MAX_OUT_CH = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic        [conv3_pkg::OP_W-1:0]    op,
    input  wire logic        [conv3_pkg::ADDR_W-1:0]  addr,
    input  wire logic signed [conv3_pkg::VAL_W-1:0]   value,
    input  wire logic        [2:0]                    out_chan,
    input  wire logic        [4:0]                    out_row,
    input  wire logic        [4:0]                    out_col,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed      [conv3_pkg::SUM_W-1:0]   conv_sum,
    output logic                                      bad_coord,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [conv3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [conv3_pkg::CFG_DAT_W-1:0] cfg_data
);

    import conv3_pkg::*;

    localparam int PIX_DEPTH = MAX_SIDE * MAX_SIDE * MAX_IN_CH;
    localparam int WGT_DEPTH = KSIZE * KSIZE * MAX_IN_CH * MAX_OUT_CH;
    localparam int PIX_AW    = $clog2(PIX_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int CIN_W     = $clog2(MAX_IN_CH + 1);
    localparam int COUT_W    = $clog2(MAX_OUT_CH + 1);
    localparam int WIDX_W    = $clog2(WGT_DEPTH + MAX_OUT_CH + 1);
    localparam int BY_W      = (PIX_AW > COORD_W + SIDE_W + 1) ? PIX_AW
                                                               : COORD_W + SIDE_W + 1;
    localparam int SQ_W      = (PIX_AW > 2 * SIDE_W) ? PIX_AW : 2 * SIDE_W;

    state_t state_reg, state_next;

    logic [5:0] in_side_reg;
    logic [3:0] in_channels_reg;
    logic [3:0] out_channels_reg;
    logic [2:0] stride_reg;
    logic [1:0] padding_reg;

    logic [SIDE_W-1:0] side_c;
    logic [CIN_W-1:0]  cin_c;
    logic [COUT_W-1:0] cout_c;
    logic [2:0]        st_c;

    logic accept;
    logic cfg_we;

    logic [2:0] oc_reg;
    logic [4:0] orow_reg;
    logic [4:0] ocol_reg;

    logic [7:0]                row_st;
    logic [7:0]                col_st;
    logic [COORD_W-1:0]        num_c;
    logic                      bad_c;
    logic [SQ_W-1:0]           sq_full;
    logic signed [BY_W-1:0]    by_full;

    logic signed [COORD_W-1:0] base_y_reg;
    logic signed [COORD_W-1:0] base_x_reg;
    logic                      bad_reg;
    logic [SIDE_W-1:0]         side_reg;
    logic [CIN_W-1:0]          cin_reg;
    logic [COUT_W-1:0]         cout_reg;
    logic [PIX_AW-1:0]         side_sq_reg;
    logic [PIX_AW-1:0]         by_side_reg;
    logic [PIX_AW-1:0]         row_base_reg;
    logic [PIX_AW-1:0]         chan_base_reg;
    logic [CIN_W-1:0]          m_reg;
    logic [1:0]                ky_reg;
    logic [1:0]                kx_reg;
    logic [WIDX_W-1:0]         widx_reg;

    logic signed [COORD_W-1:0] y_c;
    logic signed [COORD_W-1:0] x_c;
    logic signed [COORD_W-1:0] side_s;
    logic signed [BY_W-1:0]    x_w;
    logic                      tap_ok;
    logic [PIX_AW-1:0]         pidx_c;
    logic [PIX_AW-1:0]         chan_next;
    logic                      tap_last;

    logic                      pix_we;
    logic [PIX_AW-1:0]         pix_raddr;
    logic [VAL_W-1:0]          pix_rdata;
    logic                      wgt_we;
    logic [VAL_W-1:0]          wgt_rdata;

    logic                      rd_v_reg, rd_v_next;
    logic                      prod_v_reg, prod_v_next;
    logic                      ok_d_reg;
    logic signed [15:0]        prod_reg;
    logic signed [SUM_W-1:0]   acc_reg;

    logic                      out_valid_reg, out_valid_next;
    logic                      out_load;
    logic signed [SUM_W-1:0]   conv_sum_reg;
    logic                      bad_coord_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        if (in_side_reg < 6'd3)
            side_c = SIDE_W'(3);
        else if (int'(in_side_reg) > MAX_SIDE)
            side_c = SIDE_W'(MAX_SIDE);
        else
            side_c = SIDE_W'(in_side_reg);

        if (in_channels_reg == 4'd0)
            cin_c = CIN_W'(1);
        else if (int'(in_channels_reg) > MAX_IN_CH)
            cin_c = CIN_W'(MAX_IN_CH);
        else
            cin_c = CIN_W'(in_channels_reg);

        if (out_channels_reg == 4'd0)
            cout_c = COUT_W'(1);
        else if (int'(out_channels_reg) > MAX_OUT_CH)
            cout_c = COUT_W'(MAX_OUT_CH);
        else
            cout_c = COUT_W'(out_channels_reg);

        st_c = (stride_reg == 3'd0) ? 3'd1 : stride_reg;
    end

    // setup: window origin and output bound check
    always_comb
    begin
        row_st  = 8'(orow_reg) * 8'(st_c);
        col_st  = 8'(ocol_reg) * 8'(st_c);
        num_c   = COORD_W'(side_c) + COORD_W'(padding_reg) + COORD_W'(padding_reg)
                  - COORD_W'(3);
        bad_c   = (int'(oc_reg) >= int'(cout_c)) || (COORD_W'(row_st) > num_c)
                  || (COORD_W'(col_st) > num_c);
        sq_full = SQ_W'(side_c) * SQ_W'(side_c);
        by_full = base_y_reg * $signed({1'b0, side_reg});
    end

    // tap walk
    always_comb
    begin
        y_c       = base_y_reg + $signed(COORD_W'(ky_reg));
        x_c       = base_x_reg + $signed(COORD_W'(kx_reg));
        side_s    = $signed(COORD_W'(side_reg));
        x_w       = x_c;
        tap_ok    = !y_c[COORD_W-1] && !x_c[COORD_W-1] && (y_c < side_s) && (x_c < side_s);
        pidx_c    = row_base_reg + x_w[PIX_AW-1:0];
        pix_raddr = tap_ok ? pidx_c : '0;
        chan_next = chan_base_reg + side_sq_reg;
        tap_last  = (kx_reg == K_LAST) && (ky_reg == K_LAST)
                    && (m_reg == cin_reg - CIN_W'(1));
    end

    assign pix_we = accept && (op == OP_PIX) && (int'(addr) < PIX_DEPTH);
    assign wgt_we = accept && (op == OP_WGT) && (int'(addr) < WGT_DEPTH);

    conv3_ram #(
        .WIDTH (VAL_W),
        .DEPTH (PIX_DEPTH)
    ) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (PIX_AW'(addr)),
        .wdata (value),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    conv3_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WGT_DEPTH)
    ) u_wgt_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (WGT_AW'(addr)),
        .wdata (value),
        .raddr (widx_reg[WGT_AW-1:0]),
        .rdata (wgt_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        rd_v_next      = (state_reg == ST_RUN);
        prod_v_next    = rd_v_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_CONV))
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = bad_c ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (tap_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rd_v_reg && !prod_v_reg && (!out_valid_reg || !out_stall))
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_v_reg         <= 1'b0;
            prod_v_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            in_side_reg      <= 6'd3;
            in_channels_reg  <= 4'd1;
            out_channels_reg <= 4'd1;
            stride_reg       <= 3'd1;
            padding_reg      <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_v_reg      <= rd_v_next;
            prod_v_reg    <= prod_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SIDE:   in_side_reg      <= cfg_data[5:0];
                    CFG_CIN:    in_channels_reg  <= cfg_data[3:0];
                    CFG_COUT:   out_channels_reg <= cfg_data[3:0];
                    CFG_STRIDE: stride_reg       <= cfg_data[2:0];
                    CFG_PAD:    padding_reg      <= cfg_data[1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_CONV))
        begin
            oc_reg   <= out_chan;
            orow_reg <= out_row;
            ocol_reg <= out_col;
        end

        if (state_reg == ST_SETUP)
        begin
            base_y_reg  <= $signed(COORD_W'(row_st)) - $signed(COORD_W'(padding_reg));
            base_x_reg  <= $signed(COORD_W'(col_st)) - $signed(COORD_W'(padding_reg));
            bad_reg     <= bad_c;
            side_reg    <= side_c;
            cin_reg     <= cin_c;
            cout_reg    <= cout_c;
            side_sq_reg <= sq_full[PIX_AW-1:0];
            acc_reg     <= '0;
        end

        if (state_reg == ST_PREP)
        begin
            by_side_reg   <= by_full[PIX_AW-1:0];
            row_base_reg  <= by_full[PIX_AW-1:0];
            chan_base_reg <= '0;
            m_reg         <= '0;
            ky_reg        <= 2'd0;
            kx_reg        <= 2'd0;
            widx_reg      <= WIDX_W'(oc_reg);
        end

        // advance one tap per cycle
        if (state_reg == ST_RUN)
        begin
            widx_reg <= widx_reg + WIDX_W'(cout_reg);
            if (kx_reg == K_LAST)
            begin
                kx_reg <= 2'd0;
                if (ky_reg == K_LAST)
                begin
                    ky_reg        <= 2'd0;
                    m_reg         <= m_reg + CIN_W'(1);
                    chan_base_reg <= chan_next;
                    row_base_reg  <= chan_next + by_side_reg;
                end
                else
                begin
                    ky_reg       <= ky_reg + 2'd1;
                    row_base_reg <= row_base_reg + PIX_AW'(side_reg);
                end
            end
            else
            begin
                kx_reg <= kx_reg + 2'd1;
            end
        end

        ok_d_reg <= tap_ok;
        prod_reg <= ok_d_reg ? ($signed(pix_rdata) * $signed(wgt_rdata)) : 16'sd0;
        if (prod_v_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end

        if (out_load)
        begin
            conv_sum_reg  <= bad_reg ? '0 : acc_reg;
            bad_coord_reg <= bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign conv_sum  = conv_sum_reg;
    assign bad_coord = bad_coord_reg;

endmodule

`default_nettype wire
